// ===== hdl/hvg_pkg.sv =====
// Package: shared widths, constants and types for the voxel subsampler.
`timescale 1ns / 1ps
package hvg_pkg;
  localparam int BUCKETS     = 1024;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_BITS    = $clog2(BUCKETS);
  localparam int SUM_BITS    = 24 + COUNT_BITS;
  localparam int ENTRY_BITS  = 3 * 32 + 3 * SUM_BITS + COUNT_BITS;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_INV   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HX    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HY    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HZ    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MINC  = 3'd4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [31:0]         vx;
    logic [31:0]         vy;
    logic [31:0]         vz;
    logic [SUM_BITS-1:0] sx;
    logic [SUM_BITS-1:0] sy;
    logic [SUM_BITS-1:0] sz;
    logic [COUNT_BITS-1:0] cnt;
  } entry_t;

  // Divider request and reply between top level and divider.
  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] sx;
    logic [SUM_BITS-1:0] sy;
    logic [SUM_BITS-1:0] sz;
    logic [COUNT_BITS-1:0] n;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [23:0] qx;
    logic [23:0] qy;
    logic [23:0] qz;
  } div_rsp_t;
endpackage

// ===== hdl/hashed_voxel_grid_subsampler.sv =====
// Top level: hashed voxel-grid point subsampler.
//
// Input beats (in_*): opcode 0 adds a point, opcode 1 reads and clears a
// bucket. Add beats give no output; read beats give one output beat.
// Configuration writes (cfg_*) take effect at once; the user must make them only
// while idle, as the block does not enforce it. Rate: one item at a time. An add goes
// through the quantise multiply, hash multiply, bucket read and modify/write steps.
// A read waits on the bit-serial divider (one quotient bit per cycle over SUM_BITS bits).
// After reset a clearing pass writes every bucket (BUCKETS, 1024) to zero, one a
// cycle; in_tready stays low during it.
// The result sits in an output register; while the receiver stalls the next
// input beat is still taken and worked, and only a further read waits.
// Bucket table: one RAM of whole entries with a registered read, written back once.
`timescale 1ns / 1ps
module hashed_voxel_grid_subsampler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] opcode
  input  logic [0:0]   in_tuser,
  // [23:0] point_x, [47:24] point_y, [71:48] point_z, [81:72] bucket_index
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] kept, [24:1] mean_x, [48:25] mean_y, [72:49] mean_z,
  // [88:73] point_count, [120:89] collision_total
  output logic [127:0] out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_idx,
  input  logic [23:0]  cfg_data
);
  localparam int IB = hvg_pkg::IDX_BITS;
  localparam int SB = hvg_pkg::SUM_BITS;
  localparam int CB = hvg_pkg::COUNT_BITS;
  localparam int EB = hvg_pkg::ENTRY_BITS;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_QUANT = 8'b0000_0100,
    S_HASH  = 8'b0000_1000,
    S_RDWT  = 8'b0001_0000,
    S_MOD   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r;
  logic [23:0] inv_r;
  logic [15:0] hx_r, hy_r, hz_r, minc_r;
  logic [31:0] coll_r;
  logic [IB-1:0] clr_r, idx_r;
  logic op_r;
  logic signed [23:0] px_r, py_r, pz_r;
  logic [31:0] vx_r, vy_r, vz_r;
  logic [31:0] h_r;
  logic [CB-1:0] n_r;
  logic [127:0] out_r;
  logic out_v_r;

  hvg_pkg::entry_t rd_e, wr_e;
  logic we;
  logic [IB-1:0] waddr, raddr;
  hvg_pkg::div_req_t dreq;
  hvg_pkg::div_rsp_t drsp;

  hvg_ram #(.WIDTH(EB), .DEPTH(hvg_pkg::BUCKETS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_e), .raddr(raddr), .rdata(rd_e)
  );

  hvg_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // trunc(p * inv / 2^20) as 32-bit two's complement
  function automatic logic [31:0] quant(input logic signed [23:0] p,
                                        input logic [23:0] inv);
    logic [23:0] m;
    logic [47:0] pr;
    logic [31:0] q;
    m  = p[23] ? (~p + 1'b1) : p;
    pr = m * inv;
    q  = {4'd0, pr[47:20]};
    return p[23] ? (~q + 1'b1) : q;
  endfunction

  logic in_fire, out_fire;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

  // Modify step for an add
  logic hit, coll;
  hvg_pkg::entry_t add_e;
  always_comb begin
    hit  = (rd_e.vx == vx_r) && (rd_e.vy == vy_r) && (rd_e.vz == vz_r);
    coll = (rd_e.cnt != '0) && !hit;
    add_e = rd_e;
    if (coll || rd_e.cnt == '0) begin
      add_e = '0;
      add_e.vx = vx_r;
      add_e.vy = vy_r;
      add_e.vz = vz_r;
    end
    if (add_e.cnt != {CB{1'b1}}) begin
      add_e.sx  = add_e.sx + SB'(px_r);
      add_e.sy  = add_e.sy + SB'(py_r);
      add_e.sz  = add_e.sz + SB'(pz_r);
      add_e.cnt = add_e.cnt + 1'b1;
    end
  end

  logic kept_c;
  assign kept_c = {16'd0, n_r} >= {{CB{1'b0}}, minc_r};

  // Result beat; means are zero unless kept with a non-empty bucket
  logic [127:0] out_nxt;
  always_comb begin
    out_nxt = '0;
    out_nxt[0] = kept_c;
    if (kept_c && n_r != '0) begin
      out_nxt[24:1]  = drsp.qx;
      out_nxt[48:25] = drsp.qy;
      out_nxt[72:49] = drsp.qz;
    end
    out_nxt[88:73]  = (CB > 16 && n_r > CB'(16'hFFFF)) ? 16'hFFFF : 16'(n_r);
    out_nxt[120:89] = coll_r;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wr_e  = '0;
    raddr = idx_r;
    dreq  = '0;
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
      end
      S_MOD: begin
        we = 1'b1;
        if (op_r == hvg_pkg::OP_ADD) wr_e = add_e;
        dreq.start = (op_r == hvg_pkg::OP_READ);
        dreq.sx = rd_e.sx;
        dreq.sy = rd_e.sy;
        dreq.sz = rd_e.sz;
        dreq.n  = (rd_e.cnt == '0) ? CB'(1) : rd_e.cnt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      coll_r  <= '0;
      out_v_r <= 1'b0;
      inv_r <= 24'd6554;
      hx_r  <= 16'd3863;
      hy_r  <= 16'd2029;
      hz_r  <= 16'd49139;
      minc_r <= 16'd1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          hvg_pkg::REG_INV:  inv_r  <= cfg_data;
          hvg_pkg::REG_HX:   hx_r   <= cfg_data[15:0];
          hvg_pkg::REG_HY:   hy_r   <= cfg_data[15:0];
          hvg_pkg::REG_HZ:   hz_r   <= cfg_data[15:0];
          hvg_pkg::REG_MINC: minc_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_fire) out_v_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IB'(hvg_pkg::BUCKETS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_fire) begin
          op_r <= in_tuser[0];
          px_r <= in_tdata[23:0];
          py_r <= in_tdata[47:24];
          pz_r <= in_tdata[71:48];
          idx_r <= in_tdata[72 +: IB];
          state_r <= (in_tuser[0] == hvg_pkg::OP_READ) ? S_RDWT : S_QUANT;
        end
        S_QUANT: begin
          vx_r <= quant(px_r, inv_r);
          vy_r <= quant(py_r, inv_r);
          vz_r <= quant(pz_r, inv_r);
          state_r <= S_HASH;
        end
        S_HASH: begin
          idx_r <= IB'(32'(hx_r * vx_r) + 32'(hy_r * vy_r) + 32'(hz_r * vz_r));
          state_r <= S_RDWT;
        end
        S_RDWT: if (op_r == hvg_pkg::OP_ADD || !out_v_r || out_fire) begin
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (op_r == hvg_pkg::OP_ADD) begin
            if (coll && coll_r != 32'hFFFF_FFFF) coll_r <= coll_r + 1'b1;
            state_r <= S_IDLE;
          end else begin
            n_r <= rd_e.cnt;
            state_r <= S_DIV;
          end
        end
        S_DIV: if (drsp.done) state_r <= S_OUT;
        S_OUT: begin
          out_r   <= out_nxt;
          out_v_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_tready) else $error("input taken during clear");
  a_coll_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> coll_r >= $past(coll_r)) else $error("collision count fell");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped while stalled");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DIV) else $error("divider done out of turn");
`endif
endmodule

// ===== hdl/hvg_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module hvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/hvg_div.sv =====
// Restoring divider: three signed sums by one count, one quotient bit a cycle.
`timescale 1ns / 1ps
module hvg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hvg_pkg::div_req_t req,
  output hvg_pkg::div_rsp_t rsp
);
  localparam int SB = hvg_pkg::SUM_BITS;
  localparam int CB = hvg_pkg::COUNT_BITS;
  localparam int STEP_BITS = $clog2(SB + 1);

  logic [SB-1:0] qx_r, qy_r, qz_r;
  logic [CB:0]   rx_r, ry_r, rz_r;
  logic [CB-1:0] n_r;
  logic [2:0]    neg_r;
  logic [STEP_BITS-1:0] step_r;
  logic busy_r, done_r;

  function automatic logic [SB-1:0] mag(input logic [SB-1:0] s);
    return s[SB-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [CB:0] rem_step(input logic [CB:0] r, input logic b,
                                           input logic [CB-1:0] n);
    logic [CB+1:0] t;
    t = {r, b};
    return (t >= {2'b00, n}) ? CB'(0) | (CB+1)'(t - {2'b00, n}) : t[CB:0];
  endfunction

  function automatic logic [23:0] fix(input logic [SB-1:0] q, input logic ng);
    logic [SB-1:0] v;
    v = ng ? (~q + 1'b1) : q;
    return v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_BITS'(SB);
        qx_r   <= mag(req.sx);
        qy_r   <= mag(req.sy);
        qz_r   <= mag(req.sz);
        neg_r  <= {req.sz[SB-1], req.sy[SB-1], req.sx[SB-1]};
        n_r    <= req.n;
        rx_r   <= '0;
        ry_r   <= '0;
        rz_r   <= '0;
      end else if (busy_r) begin
        rx_r <= rem_step(rx_r, qx_r[SB-1], n_r);
        ry_r <= rem_step(ry_r, qy_r[SB-1], n_r);
        rz_r <= rem_step(rz_r, qz_r[SB-1], n_r);
        qx_r <= {qx_r[SB-2:0], ({rx_r, qx_r[SB-1]} >= {1'b0, n_r})};
        qy_r <= {qy_r[SB-2:0], ({ry_r, qy_r[SB-1]} >= {1'b0, n_r})};
        qz_r <= {qz_r[SB-2:0], ({rz_r, qz_r[SB-1]} >= {1'b0, n_r})};
        step_r <= step_r - 1'b1;
        if (step_r == STEP_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.qx   = fix(qx_r, neg_r[0]);
  assign rsp.qy   = fix(qy_r, neg_r[1]);
  assign rsp.qz   = fix(qz_r, neg_r[2]);
endmodule
